/* rtl/bdt_pkg.sv */
// ----------------------------------------------------------------------------
// Bear dispersion tensor package
// Shared types, register indexes and table constants of the dispersion block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdt_pkg;

	localparam int MAX_DIM = 3;
	localparam int NOUT = 6;

	// Configuration register indexes.
	localparam logic [1:0] REG_LONG  = 2'd0;
	localparam logic [1:0] REG_TRANS = 2'd1;
	localparam logic [1:0] REG_DIM   = 2'd2;
	localparam logic [1:0] DIM_RESET = 2'd3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	// Row and column of each result entry: xx, yy, zz, xy, xz, yz.
	localparam int ROW_OF [NOUT] = '{0, 1, 2, 0, 0, 1};
	localparam int COL_OF [NOUT] = '{0, 1, 2, 1, 2, 2};

	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [16:0]        water_content;
		logic [16:0]        porosity;
	} item_t;

	typedef struct packed {
		logic signed [31:0] d_xx;
		logic signed [31:0] d_yy;
		logic signed [31:0] d_zz;
		logic signed [31:0] d_xy;
		logic signed [31:0] d_xz;
		logic signed [31:0] d_yz;
	} result_t;

	typedef struct packed {
		logic [30:0] long_disp;
		logic [30:0] trans_disp;
		logic [1:0]  space_dim;
	} cfg_t;

	// Classified item: velocity split into sign and magnitude per lane.
	typedef struct packed {
		logic [1:0]       dims;
		logic [2:0]       neg;
		logic [2:0][31:0] mag;
		logic [16:0]      wc;
		logic [16:0]      phi;
	} cls_t;

	typedef struct packed {
		logic [FIFO_AW:0] count;
		logic             full;
		logic             empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

/* rtl/bdt_front.sv */
// ----------------------------------------------------------------------------
// Bear dispersion tensor front end
// Accepts cells, masks unused dimensions and splits velocity into sign and
// magnitude before handing the item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bdt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  bdt_pkg::item_t       item,
	input  logic [1:0]           space_dim,
	input  bdt_pkg::fifo_stat_t  fstat,
	output logic                 cls_valid,
	output bdt_pkg::cls_t        cls
);

	logic          accept;
	logic [1:0]    dims;
	logic [2:0][31:0] raw;
	bdt_pkg::cls_t cls_c;
	logic          cls_valid_q;
	bdt_pkg::cls_t cls_q;

	// Keep headroom so the item held here always finds a queue slot.
	assign busy = fstat.count >= (bdt_pkg::FIFO_AW + 1)'(bdt_pkg::FIFO_DEPTH - 2);
	assign accept = start && !busy;

	assign dims = (space_dim > 2'(bdt_pkg::MAX_DIM)) ? 2'(bdt_pkg::MAX_DIM) : space_dim;

	always_comb begin
		raw[0] = item.vel_x;
		raw[1] = item.vel_y;
		raw[2] = item.vel_z;
		cls_c.dims = dims;
		cls_c.wc = item.water_content;
		cls_c.phi = item.porosity;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < dims) begin
				cls_c.neg[i] = raw[i][31];
				cls_c.mag[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
			end else begin
				cls_c.neg[i] = 1'b0;
				cls_c.mag[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid_q <= 1'b0;
		end else begin
			cls_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_q <= cls_c;
		end
	end

	assign cls_valid = cls_valid_q;
	assign cls = cls_q;

endmodule

`default_nettype wire

/* rtl/bdt_fifo.sv */
// ----------------------------------------------------------------------------
// Bear dispersion tensor item queue
// Short queue of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bdt_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bdt_pkg::cls_t       wdata,
	input  logic                pop,
	output bdt_pkg::cls_t       rdata,
	output bdt_pkg::fifo_stat_t stat
);

	bdt_pkg::cls_t mem_q [bdt_pkg::FIFO_DEPTH];
	logic [bdt_pkg::FIFO_AW-1:0] wptr_q;
	logic [bdt_pkg::FIFO_AW-1:0] rptr_q;
	logic [bdt_pkg::FIFO_AW:0]   count_q;
	logic full;
	logic empty;
	logic do_push;
	logic do_pop;

	assign full = count_q == (bdt_pkg::FIFO_AW + 1)'(bdt_pkg::FIFO_DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata = mem_q[rptr_q];
	assign stat.count = count_q;
	assign stat.full = full;
	assign stat.empty = empty;

endmodule

`default_nettype wire

/* rtl/bdt_back.sv */
// ----------------------------------------------------------------------------
// Bear dispersion tensor back end
// Fully pipelined datapath: pore velocity division, scaling, square root,
// outer product division, dispersivity and water content scaling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module bdt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  bdt_pkg::cls_t    in_cls,
	input  bdt_pkg::cfg_t    cfg,
	output logic             done,
	output bdt_pkg::result_t result
);

	localparam int AW = 48;
	localparam int BW = 31;
	localparam int NW = 32;
	localparam int QW = 31;
	localparam int SQ_STEPS = 32;
	localparam int NO = bdt_pkg::NOUT;

	typedef struct packed {
		logic [4:0]  sh;
		logic [16:0] wc;
		logic [1:0]  dims;
		logic        zero;
		logic [2:0]  neg;
	} side_t;

	typedef struct packed {
		logic [2:0][AW-1:0] num;
		logic [2:0][AW-1:0] quo;
		logic [2:0][16:0]   rem;
		logic [16:0]        phi;
		side_t              side;
	} ad_t;

	typedef struct packed {
		logic [63:0]        x;
		logic [34:0]        rem;
		logic [NW-1:0]      root;
		logic [2:0][BW-1:0] b;
		side_t              side;
	} sq_t;

	typedef struct packed {
		logic [NO-1:0][QW-1:0] lo;
		logic [NO-1:0][NW-1:0] rem;
		logic [NO-1:0][QW-1:0] quo;
		logic [NW-1:0]         n;
		logic [46:0]           diag;
		logic [NO-1:0]         sgn;
		side_t                 side;
	} qd_t;

	// One restoring division bit per lane: magnitude << 16 over porosity.
	function automatic ad_t ad_step(ad_t x);
		ad_t y;
		logic [17:0] t;
		y = x;
		for (int i = 0; i < 3; i++) begin
			t = {x.rem[i], x.num[i][AW-1]};
			y.num[i] = {x.num[i][AW-2:0], 1'b0};
			if (t >= {1'b0, x.phi}) begin
				y.rem[i] = 17'(t - {1'b0, x.phi});
				y.quo[i] = {x.quo[i][AW-2:0], 1'b1};
			end else begin
				y.rem[i] = t[16:0];
				y.quo[i] = {x.quo[i][AW-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	// One root bit of the digit-by-digit square root.
	function automatic sq_t sq_step(sq_t x);
		sq_t y;
		logic [34:0] t;
		logic [34:0] trial;
		y = x;
		t = {x.rem[32:0], x.x[63:62]};
		trial = {1'b0, x.root, 2'b01};
		y.x = {x.x[61:0], 2'b00};
		if (t >= trial) begin
			y.rem = t - trial;
			y.root = {x.root[NW-2:0], 1'b1};
		end else begin
			y.rem = t;
			y.root = {x.root[NW-2:0], 1'b0};
		end
		return y;
	endfunction

	// One quotient bit per entry of the outer product over the norm.
	function automatic qd_t qd_step(qd_t x);
		qd_t y;
		logic [NW:0] t;
		y = x;
		for (int k = 0; k < NO; k++) begin
			t = {x.rem[k], x.lo[k][QW-1]};
			y.lo[k] = {x.lo[k][QW-2:0], 1'b0};
			if (t >= {1'b0, x.n}) begin
				y.rem[k] = NW'(t - {1'b0, x.n});
				y.quo[k] = {x.quo[k][QW-2:0], 1'b1};
			end else begin
				y.rem[k] = t[NW-1:0];
				y.quo[k] = {x.quo[k][QW-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	logic        dneg;
	logic [30:0] dmag;

	assign dneg = cfg.long_disp < cfg.trans_disp;
	assign dmag = dneg ? (cfg.trans_disp - cfg.long_disp) : (cfg.long_disp - cfg.trans_disp);

	// Pore velocity division.
	ad_t         ad_s1 [AW+1];
	logic [AW:0] ad_v_s1;

	// Scaling and squares.
	logic               v_s2, v_s3, v_s4, v_s5;
	logic [2:0][AW-1:0] a_s2;
	logic [AW-1:0]      mx_s2;
	side_t              side_s2, side_s3, side_s4, side_s5;
	logic [2:0][BW-1:0] b_s3, b_s4, b_s5;
	logic [2:0][61:0]   sq_s4;
	logic [63:0]        ss_s5;
	logic [AW-1:0]      mx_c;
	logic [4:0]         sh_c;

	// Square root.
	sq_t               sq_s6 [SQ_STEPS+1];
	logic [SQ_STEPS:0] sq_v_s6;

	// Outer product and transverse term.
	logic                 v_s7;
	logic [NW-1:0]        n_s7;
	logic [NO-1:0][61:0]  p_s7;
	logic [46:0]          diag_s7;
	logic [NO-1:0]        sgn_s7;
	side_t                side_s7;
	logic [62:0]          dt_c;

	// Outer product division.
	qd_t         qd_s8 [QW+1];
	logic [QW:0] qd_v_s8;

	// Tail stages.
	logic                v_s9, v_s10, v_s11, v_s12;
	logic [NO-1:0][45:0] an_s9;
	logic [46:0]         diag_s9;
	logic [NO-1:0]       sgn_s9;
	side_t               side_s9, side_s10, side_s11;
	logic [NO-1:0][47:0] emag_s10;
	logic [NO-1:0]       eneg_s10, eneg_s11;
	logic [NO-1:0][48:0] r_s11;
	logic [NO-1:0][31:0] d_s12;
	logic [NO-1:0][61:0] anp_c;
	logic [NO-1:0][47:0] emag_c;
	logic [NO-1:0]       eneg_c;
	logic [NO-1:0][64:0] rp_c;
	logic [NO-1:0][31:0] d_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ad_v_s1 <= '0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			sq_v_s6 <= '0;
			v_s7 <= 1'b0;
			qd_v_s8 <= '0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			ad_v_s1 <= {ad_v_s1[AW-1:0], in_valid};
			v_s2 <= ad_v_s1[AW];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			sq_v_s6 <= {sq_v_s6[SQ_STEPS-1:0], v_s5};
			v_s7 <= sq_v_s6[SQ_STEPS];
			qd_v_s8 <= {qd_v_s8[QW-1:0], v_s7};
			v_s9 <= qd_v_s8[QW];
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_comb begin
		mx_c = ad_s1[AW].quo[0];
		for (int i = 1; i < 3; i++) begin
			if (ad_s1[AW].quo[i] > mx_c) begin
				mx_c = ad_s1[AW].quo[i];
			end
		end
	end

	// Right shift that brings the largest component below 2^31.
	always_comb begin
		sh_c = '0;
		for (int j = BW; j < AW; j++) begin
			if (mx_s2[j]) begin
				sh_c = 5'(j - BW + 1);
			end
		end
	end

	assign dt_c = {32'd0, cfg.trans_disp} * {31'd0, sq_s6[SQ_STEPS].root};

	always_comb begin
		for (int k = 0; k < NO; k++) begin
			anp_c[k] = {31'd0, dmag} * {31'd0, qd_s8[QW].quo[k]};
		end
	end

	// Signed sum of the longitudinal term and, on the diagonal, the transverse term.
	always_comb begin
		logic [46:0] dk;
		logic [46:0] an;
		for (int k = 0; k < NO; k++) begin
			dk = (k < 3) ? diag_s9 : 47'd0;
			an = {1'b0, an_s9[k]};
			if (sgn_s9[k]) begin
				eneg_c[k] = an > dk;
				emag_c[k] = eneg_c[k] ? 48'(an - dk) : 48'(dk - an);
			end else begin
				eneg_c[k] = 1'b0;
				emag_c[k] = 48'(dk) + 48'(an);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NO; k++) begin
			rp_c[k] = {17'd0, emag_s10[k]} * {48'd0, side_s10.wc};
		end
	end

	// Undo the scaling shift with saturation, then apply the sign; entries of unused dimensions or zero cells are cleared.
	always_comb begin
		logic [31:0] thr;
		logic [31:0] mag;
		thr = 32'h8000_0000 >> side_s11.sh;
		for (int k = 0; k < NO; k++) begin
			if (r_s11[k] > {17'd0, thr}) begin
				mag = 32'h8000_0000;
			end else begin
				mag = 32'(r_s11[k] << side_s11.sh);
			end
			if (eneg_s11[k]) begin
				d_c[k] = ~mag + 32'd1;
			end else if (mag > 32'h7FFF_FFFF) begin
				d_c[k] = 32'h7FFF_FFFF;
			end else begin
				d_c[k] = mag;
			end
			if (side_s11.zero || (2'(bdt_pkg::ROW_OF[k]) >= side_s11.dims)
					|| (2'(bdt_pkg::COL_OF[k]) >= side_s11.dims)) begin
				d_c[k] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ad_s1[0].num[i] <= {in_cls.mag[i], 16'd0};
			ad_s1[0].quo[i] <= '0;
			ad_s1[0].rem[i] <= '0;
		end
		ad_s1[0].phi <= in_cls.phi;
		ad_s1[0].side.sh <= '0;
		ad_s1[0].side.wc <= in_cls.wc;
		ad_s1[0].side.dims <= in_cls.dims;
		ad_s1[0].side.zero <= in_cls.phi == '0;
		ad_s1[0].side.neg <= in_cls.neg;
		for (int k = 0; k < AW; k++) begin
			ad_s1[k+1] <= ad_step(ad_s1[k]);
		end

		a_s2 <= ad_s1[AW].quo;
		mx_s2 <= mx_c;
		side_s2 <= ad_s1[AW].side;

		for (int i = 0; i < 3; i++) begin
			b_s3[i] <= BW'(a_s2[i] >> sh_c);
		end
		side_s3 <= {sh_c, side_s2.wc, side_s2.dims, side_s2.zero, side_s2.neg};

		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= {31'd0, b_s3[i]} * {31'd0, b_s3[i]};
		end
		b_s4 <= b_s3;
		side_s4 <= side_s3;

		ss_s5 <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
		b_s5 <= b_s4;
		side_s5 <= side_s4;

		sq_s6[0].x <= ss_s5;
		sq_s6[0].rem <= '0;
		sq_s6[0].root <= '0;
		sq_s6[0].b <= b_s5;
		sq_s6[0].side <= side_s5;
		for (int k = 0; k < SQ_STEPS; k++) begin
			sq_s6[k+1] <= sq_step(sq_s6[k]);
		end

		n_s7 <= sq_s6[SQ_STEPS].root;
		for (int k = 0; k < NO; k++) begin
			p_s7[k] <= {31'd0, sq_s6[SQ_STEPS].b[bdt_pkg::ROW_OF[k]]}
				* {31'd0, sq_s6[SQ_STEPS].b[bdt_pkg::COL_OF[k]]};
			sgn_s7[k] <= dneg ^ sq_s6[SQ_STEPS].side.neg[bdt_pkg::ROW_OF[k]]
				^ sq_s6[SQ_STEPS].side.neg[bdt_pkg::COL_OF[k]];
		end
		diag_s7 <= dt_c[62:16];
		side_s7 <= {sq_s6[SQ_STEPS].side.sh, sq_s6[SQ_STEPS].side.wc,
			sq_s6[SQ_STEPS].side.dims,
			(sq_s6[SQ_STEPS].side.zero || (sq_s6[SQ_STEPS].root == '0)),
			sq_s6[SQ_STEPS].side.neg};

		for (int k = 0; k < NO; k++) begin
			qd_s8[0].rem[k] <= {1'b0, p_s7[k][61:31]};
			qd_s8[0].lo[k] <= p_s7[k][30:0];
			qd_s8[0].quo[k] <= '0;
		end
		qd_s8[0].n <= n_s7;
		qd_s8[0].diag <= diag_s7;
		qd_s8[0].sgn <= sgn_s7;
		qd_s8[0].side <= side_s7;
		for (int k = 0; k < QW; k++) begin
			qd_s8[k+1] <= qd_step(qd_s8[k]);
		end

		for (int k = 0; k < NO; k++) begin
			an_s9[k] <= anp_c[k][61:16];
		end
		diag_s9 <= qd_s8[QW].diag;
		sgn_s9 <= qd_s8[QW].sgn;
		side_s9 <= qd_s8[QW].side;

		emag_s10 <= emag_c;
		eneg_s10 <= eneg_c;
		side_s10 <= side_s9;

		for (int k = 0; k < NO; k++) begin
			r_s11[k] <= rp_c[k][64:16];
		end
		eneg_s11 <= eneg_s10;
		side_s11 <= side_s10;

		d_s12 <= d_c;
	end

	assign done = v_s12;
	assign result.d_xx = d_s12[0];
	assign result.d_yy = d_s12[1];
	assign result.d_zz = d_s12[2];
	assign result.d_xy = d_s12[3];
	assign result.d_xz = d_s12[4];
	assign result.d_yz = d_s12[5];

endmodule

`default_nettype wire

/* rtl/bear_dispersion_tensor.sv */
// ----------------------------------------------------------------------------
// Bear mechanical dispersion tensor
// Top level: configuration registers, front end, item queue and back end.
// ----------------------------------------------------------------------------
// The block takes one cell per clock cycle while busy is low. Its six tensor
// entries, marked by done for one cycle, follow the front end register, the
// item queue and the bit-serial back end pipelines: 48 stages for the division
// by porosity, 32 for the square root of the norm and 31 for the division of
// the outer product by the norm. The receiver cannot stall the block, so busy
// stays low in normal use. Dispersivities and dimension count are to be written
// by the user only while no cell is in flight; the block does not enforce this.
`default_nettype none

module bear_dispersion_tensor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bdt_pkg::item_t   item,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [30:0]      wr_data,
	output logic             done,
	output bdt_pkg::result_t result
);

	bdt_pkg::cfg_t       cfg_q;
	logic                cls_valid;
	bdt_pkg::cls_t       cls;
	bdt_pkg::cls_t       head;
	bdt_pkg::fifo_stat_t fstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_disp <= '0;
			cfg_q.trans_disp <= '0;
			cfg_q.space_dim <= bdt_pkg::DIM_RESET;
		end else if (wr_en) begin
			case (wr_index)
				bdt_pkg::REG_LONG:  cfg_q.long_disp <= wr_data;
				bdt_pkg::REG_TRANS: cfg_q.trans_disp <= wr_data;
				bdt_pkg::REG_DIM:   cfg_q.space_dim <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	bdt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.space_dim (cfg_q.space_dim),
		.fstat     (fstat),
		.cls_valid (cls_valid),
		.cls       (cls)
	);

	bdt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cls_valid),
		.wdata  (cls),
		.pop    (!fstat.empty),
		.rdata  (head),
		.stat   (fstat)
	);

	bdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!fstat.empty),
		.in_cls   (head),
		.cfg      (cfg_q),
		.done     (done),
		.result   (result)
	);

	// The back end drains the queue every cycle, so it never fills.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cls_valid && fstat.full))
		else $error("item queue overflow");

	a_queue_low: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.count <= (bdt_pkg::FIFO_AW + 1)'(1))
		else $error("item queue holds more than one item");

	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		cls_valid |=> !fstat.empty)
		else $error("classified item was not queued");

endmodule

`default_nettype wire

/* dv/tb_bear_dispersion_tensor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of the Bear dispersion tensor
// Drives cells through the command port under several dispersivity and
// dimension settings and compares every tensor with a predictor or a known value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bear_dispersion_tensor;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 140;
	localparam int RAND_PER_PHASE = 150;

	typedef logic [bdt_pkg::NOUT-1:0][31:0] words_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	bdt_pkg::item_t item = '0;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [30:0] wr_data = '0;
	logic done;
	bdt_pkg::result_t result;

	// Typed expectation that travels with the item being offered.
	logic known_q = 1'b0;
	bdt_pkg::result_t known_res_q = '0;

	logic [30:0] alpha_l = '0;
	logic [30:0] alpha_t = '0;
	logic [1:0] dim_cnt = bdt_pkg::DIM_RESET;

	bdt_pkg::result_t tensor_q[$];
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;
	int unsigned idle_pct = 0;

	bear_dispersion_tensor i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.done(done),
		.result(result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic bdt_pkg::result_t tensor_of(bdt_pkg::item_t it);
		longint unsigned a[3], b[3], mag, raw, wc, phi, mx, sumsq, x, bitv, n;
		longint unsigned dmag, diag_t, q, an, emag, r, m;
		longint e, res;
		bit neg[3];
		bit dneg, eneg;
		int unsigned dims, s;
		int r0, c0;
		words_t w;
		w = '0;
		dims = (dim_cnt > bdt_pkg::MAX_DIM) ? bdt_pkg::MAX_DIM : dim_cnt;
		wc = it.water_content;
		phi = it.porosity;
		if (phi == 0)
			return bdt_pkg::result_t'(w);
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			raw = (i == 0) ? 64'(unsigned'(it.vel_x)) :
				(i == 1) ? 64'(unsigned'(it.vel_y)) : 64'(unsigned'(it.vel_z));
			neg[i] = 1'b0;
			a[i] = 0;
			if (i < dims) begin
				neg[i] = raw[31];
				mag = neg[i] ? (64'h1_0000_0000 - raw) : raw;
				a[i] = (mag << 16) / phi;
				if (a[i] > mx)
					mx = a[i];
			end
		end
		s = 0;
		while ((mx >> s) >= 64'h8000_0000)
			s++;
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			b[i] = a[i] >> s;
			sumsq += b[i] * b[i];
		end
		// Bitwise integer square root, rounded down.
		x = sumsq;
		n = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= n + bitv) begin
				x -= n + bitv;
				n = (n >> 1) + bitv;
			end else begin
				n >>= 1;
			end
			bitv >>= 2;
		end
		if (n == 0)
			return bdt_pkg::result_t'(w);
		dneg = alpha_l < alpha_t;
		dmag = dneg ? 64'(alpha_t - alpha_l) : 64'(alpha_l - alpha_t);
		diag_t = (64'(alpha_t) * n) >> 16;
		for (int k = 0; k < bdt_pkg::NOUT; k++) begin
			r0 = bdt_pkg::ROW_OF[k];
			c0 = bdt_pkg::COL_OF[k];
			if (r0 < dims && c0 < dims) begin
				q = (b[r0] * b[c0]) / n;
				an = (dmag * q) >> 16;
				e = (dneg ^ neg[r0] ^ neg[c0]) ? -longint'(an) : longint'(an);
				if (r0 == c0)
					e += longint'(diag_t);
				eneg = e < 0;
				emag = eneg ? longint'(-e) : e;
				r = (emag >> 16) * wc + (((emag & 64'hFFFF) * wc) >> 16);
				m = (r > (64'h8000_0000 >> s)) ? 64'h8000_0000 : (r << s);
				if (eneg) begin
					res = -longint'(m);
				end else begin
					if (m > 64'h7FFF_FFFF)
						m = 64'h7FFF_FFFF;
					res = longint'(m);
				end
				w[bdt_pkg::NOUT-1-k] = res[31:0];
			end
		end
		return bdt_pkg::result_t'(w);
	endfunction

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3, 4: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
			5: return 32'($signed($urandom_range(0, 64)) - 32);
			default: return $urandom;
		endcase
	endfunction

	function automatic bdt_pkg::item_t rand_item();
		bdt_pkg::item_t it;
		it.vel_x = rand_vel();
		it.vel_y = rand_vel();
		it.vel_z = rand_vel();
		it.water_content = ($urandom_range(0, 7) == 0) ? 17'($urandom) :
			17'($urandom_range(0, 65536));
		case ($urandom_range(0, 15))
			0: it.porosity = '0;
			1: it.porosity = 17'($urandom);
			2: it.porosity = 17'd1;
			default: it.porosity = 17'($urandom_range(1, 65536));
		endcase
		return it;
	endfunction

	// Acceptance of cells and checking of tensors.
	always @(posedge clk) begin
		words_t ew, aw;
		string names[bdt_pkg::NOUT];
		bdt_pkg::result_t exp_res;
		names = '{"d_xx", "d_yy", "d_zz", "d_xy", "d_xz", "d_yz"};
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (start && !busy) begin
			tensor_q.push_back(known_q ? known_res_q : tensor_of(item));
		end
		if (done) begin
			if (tensor_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: tensor with no cell outstanding: %h", result);
			end else begin
				exp_res = tensor_q.pop_front();
				ew = words_t'(exp_res);
				aw = words_t'(result);
				for (int k = 0; k < bdt_pkg::NOUT; k++) begin
					if (ew[bdt_pkg::NOUT-1-k] !== aw[bdt_pkg::NOUT-1-k]) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: %s expected %h got %h", names[k],
								ew[bdt_pkg::NOUT-1-k], aw[bdt_pkg::NOUT-1-k]);
					end
				end
			end
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(bdt_pkg::item_t it, logic known, bdt_pkg::result_t known_res);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		known_q <= known;
		known_res_q <= known_res;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic settle();
		start <= 1'b0;
		known_q <= 1'b0;
		while (tensor_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [30:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			bdt_pkg::REG_LONG: alpha_l = data;
			bdt_pkg::REG_TRANS: alpha_t = data;
			bdt_pkg::REG_DIM: dim_cnt = data[1:0];
			default: ;
		endcase
	endtask

	initial begin
		bdt_pkg::item_t dir_tab[$];
		logic [30:0] set_l[6], set_t[6];
		logic [1:0] set_d[6];
		dir_tab = '{
			'{32'sd0, 32'sd0, 32'sd0, 17'd65536, 17'd65536},
			'{32'h7FFF_FFFF, 32'sd0, 32'sd0, 17'd65536, 17'd65536},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'd65536, 17'd1},
			'{32'sd1, -32'sd1, 32'sd1, 17'd1, 17'd65536},
			'{32'sd65536, 32'sd65536, 32'sd65536, 17'd65536, 17'd0},
			'{32'sd65536, -32'sd65536, 32'sd65536, 17'd0, 17'd65536},
			'{32'sd1000, 32'sd2000, -32'sd3000, 17'h1FFFF, 17'h1FFFF},
			'{-32'sd65536, 32'sd65536, 32'sd0, 17'd32768, 17'd16384},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF, 17'd1},
			'{32'sd1, 32'sd0, 32'sd0, 17'd65536, 17'd65536},
			'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0, 17'h0AAAA, 17'h15555}
		};
		set_l = '{31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd131072, 31'd0};
		set_t = '{31'd4096, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd6554, 31'd327680, 31'd0};
		set_d = '{2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd3};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset dispersivities every entry is zero.
		foreach (dir_tab[j])
			send(dir_tab[j], 1'b1, '0);
		settle();
		write_reg(bdt_pkg::REG_LONG, 31'd98304);
		write_reg(bdt_pkg::REG_TRANS, 31'd9830);
		foreach (dir_tab[j])
			send(dir_tab[j], 1'b0, '0);
		settle();
		// An index past the register file must leave the settings alone.
		write_reg(2'd3, 31'h7FFF_FFFF);
		for (int j = 0; j < 20; j++)
			send(rand_item(), 1'b0, '0);
		settle();

		for (int p = 0; p < 6; p++) begin
			idle_pct = (p < 2) ? 7 : (p < 4) ? 82 : 0;
			write_reg(bdt_pkg::REG_LONG, set_l[p]);
			write_reg(bdt_pkg::REG_TRANS, set_t[p]);
			write_reg(bdt_pkg::REG_DIM, set_d[p]);
			for (int j = 0; j < RAND_PER_PHASE; j++)
				send(rand_item(), 1'b0, '0);
			settle();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
